// ===== sv/box_average_downscale_defines.svh =====
// Assertion macros shared by the box average downscale checks.
`ifndef BOX_AVERAGE_DOWNSCALE_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define BXAVG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bxavg check failed");

// Next-cycle implication, off during reset.
`define BXAVG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bxavg check failed");

// Holds in the cycle after reset is seen.
`define BXAVG_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("bxavg reset check failed");

`endif

// ===== sv/bxavg_pkg.sv =====
// Shared types and constants of the box average downscaler.
`timescale 1ns / 1ps

package bxavg_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS  = 2'd2;

  localparam int SCALE_REG_W = 5;
  localparam int COLS_REG_W  = 11;
  localparam int ROWS_REG_W  = 13;

  localparam int ROW_LIMIT = 4096;
  localparam int ROW_W     = 12;

  localparam int PIX_W  = 8;
  localparam int MEAN_W = 8;
  localparam int OUTX_W = 10;
  localparam int OUTY_W = 12;

  // Position and flag of one output pixel, carried alongside the sums.
  typedef struct packed {
    logic [OUTX_W-1:0] out_x;
    logic [OUTY_W-1:0] out_y;
    logic              frame_last;
  } bxavg_tag_t;

endpackage

// ===== sv/bxavg_if.sv =====
// Stream interfaces: source pixel words in, averaged pixel words out.
`timescale 1ns / 1ps

interface bxavg_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                output ready);
endinterface

interface bxavg_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [9:0]  out_x;
  logic [11:0] out_y;
  logic        frame_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_x, output out_y, output frame_last, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_x, input out_y, input frame_last, output ready);
endinterface

// ===== sv/bxavg_divider.sv =====
// Pipelined restoring divider: three block sums by the block area, one bit a stage.
`timescale 1ns / 1ps

module bxavg_divider #(
  parameter int SUM_W  = 16,
  parameter int AREA_W = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [2:0][SUM_W-1:0]           in_sum,
  input  bxavg_pkg::bxavg_tag_t           in_tag,
  input  logic [AREA_W-1:0]               area,
  output logic                            out_valid,
  output logic [2:0][bxavg_pkg::MEAN_W-1:0] out_mean,
  output bxavg_pkg::bxavg_tag_t           out_tag
);

  localparam int QW    = bxavg_pkg::MEAN_W;
  localparam int CMP_W = SUM_W + QW;

  logic                  st_valid [QW+1];
  logic [2:0][SUM_W-1:0] st_rem   [QW+1];
  logic [2:0][QW-1:0]    st_quot  [QW+1];
  bxavg_pkg::bxavg_tag_t st_tag   [QW+1];

  // stage 0 holds the raw sums
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_rem[0]  <= in_sum;
      st_quot[0] <= '0;
      st_tag[0]  <= in_tag;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int BIT = QW - 1 - j;

    logic [CMP_W-1:0]      dsh;
    logic [2:0][SUM_W-1:0] rem_next;
    logic [2:0][QW-1:0]    quot_next;

    always_comb begin
      dsh = CMP_W'(area) << BIT;
      for (int k = 0; k < 3; k++) begin
        if (CMP_W'(st_rem[j][k]) >= dsh) begin
          rem_next[k]  = SUM_W'(CMP_W'(st_rem[j][k]) - dsh);
          quot_next[k] = {st_quot[j][k][QW-2:0], 1'b1};
        end else begin
          rem_next[k]  = st_rem[j][k];
          quot_next[k] = {st_quot[j][k][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[j+1] <= 1'b0;
      end else if (adv) begin
        st_valid[j+1] <= st_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_rem[j+1]  <= rem_next;
        st_quot[j+1] <= quot_next;
        st_tag[j+1]  <= st_tag[j];
      end
    end
  end

  assign out_valid = st_valid[QW];
  assign out_mean  = st_quot[QW];
  assign out_tag   = st_tag[QW];

endmodule

// ===== sv/box_average_downscale.sv =====
// Top level of the box average downscaler.
`timescale 1ns / 1ps

// Integer box-filter shrink of an RGB pixel stream.
//
// pix takes source pixel words in raster order; res gives one averaged word
// each time the bottom-right pixel of a whole scale x scale block arrives,
// with its column and row in the scaled image and frame_last on the final
// block. Pixels right of or below the last whole block are taken and dropped.
// cfg_write/cfg_index/cfg_data set scale, columns and rows; any write, also to
// an unused index, restarts the frame. Write only while the stream is idle.
//
// Throughput: one pixel per cycle while no result word is held up on res. Path from
// the edge that takes the pixel closing a block to its result word on res: the
// column-sum memory read rides that same edge, the add and write-back follow
// into divider stage 0 (same-column hits forwarded from the last write), then eight
// restoring division stages, one quotient bit each.
// A stalled receiver freezes the whole pipeline, memory port included, and
// pix.ready drops with it; nothing is lost or repeated.
// Reset: registers go to scale 1, 1024 columns, 768 rows, counters to zero.
// The sum memory is not cleared; the first pixel of every block overwrites
// its column entry, so no stale entry is ever read.
module box_average_downscale #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_SCALE   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bxavg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0]    cfg_data,
  bxavg_pix_if.sink                           pix,
  bxavg_res_if.source                         res
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int SC_W   = $clog2(MAX_SCALE + 1);
  localparam int CIB_W  = $clog2(MAX_SCALE);
  localparam int AREA_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
  localparam int SUM_W  = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);
  localparam int ROW_W  = bxavg_pkg::ROW_W;

  // configuration registers
  logic [bxavg_pkg::SCALE_REG_W-1:0] scale_reg;
  logic [bxavg_pkg::COLS_REG_W-1:0]  cols_reg;
  logic [bxavg_pkg::ROWS_REG_W-1:0]  rows_reg;

  // effective (clamped) settings
  logic [31:0]                       s_wide, c_wide, r_wide;
  logic [SC_W-1:0]                   scale;
  logic [CNT_W-1:0]                  cols;
  logic [bxavg_pkg::ROWS_REG_W-1:0]  rows;
  logic [AREA_W-1:0]                 area;

  // position counters
  logic [COL_W-1:0] src_col, blk_x, col_base;
  logic [ROW_W-1:0] src_row, blk_y, row_base;
  logic [CIB_W-1:0] cib, rib;

  logic adv, accept, col_wrap, row_wrap, cib_wrap, rib_wrap;
  logic in_block, first, last, frame_end, acc_blk;

  // read/modify stage
  logic                  a_valid, a_first, a_last;
  logic [COL_W-1:0]      a_addr;
  logic [2:0][7:0]       a_px;
  bxavg_pkg::bxavg_tag_t a_tag;
  logic [2:0][SUM_W-1:0] rd_data, a_base, a_sum;

  // last write-back, for a read that raced it
  logic                  wb_valid;
  logic [COL_W-1:0]      wb_addr;
  logic [2:0][SUM_W-1:0] wb_data;

  logic [2:0][SUM_W-1:0] sum_mem [MAX_COLUMNS];

  logic                                 div_valid;
  logic [2:0][bxavg_pkg::MEAN_W-1:0]    div_mean;
  bxavg_pkg::bxavg_tag_t                div_tag;

  always_comb begin
    if (scale_reg == '0) s_wide = 32'd1;
    else if (32'(scale_reg) > 32'(MAX_SCALE)) s_wide = 32'(MAX_SCALE);
    else s_wide = 32'(scale_reg);

    if (cols_reg == '0) c_wide = 32'd1;
    else if (32'(cols_reg) > 32'(MAX_COLUMNS)) c_wide = 32'(MAX_COLUMNS);
    else c_wide = 32'(cols_reg);

    if (rows_reg == '0) r_wide = 32'd1;
    else if (32'(rows_reg) > 32'(bxavg_pkg::ROW_LIMIT)) r_wide = 32'(bxavg_pkg::ROW_LIMIT);
    else r_wide = 32'(rows_reg);

    scale = SC_W'(s_wide);
    cols  = CNT_W'(c_wide);
    rows  = bxavg_pkg::ROWS_REG_W'(r_wide);
    area  = AREA_W'(s_wide * s_wide);
  end

  // whole pipeline moves unless a result word is waiting
  assign adv       = !div_valid || res.ready;
  assign pix.ready = adv;
  assign accept    = pix.valid && adv;

  // block bounds from the block's first column/row, no division needed
  always_comb begin
    col_wrap = (32'(src_col) + 32'd1) >= 32'(cols);
    row_wrap = (32'(src_row) + 32'd1) >= 32'(rows);
    cib_wrap = (32'(cib) + 32'd1) >= 32'(scale);
    rib_wrap = (32'(rib) + 32'd1) >= 32'(scale);
    in_block = ((32'(col_base) + 32'(scale)) <= 32'(cols)) &&
               ((32'(row_base) + 32'(scale)) <= 32'(rows));
    first    = (cib == '0) && (rib == '0);
    last     = cib_wrap && rib_wrap;
    // no further whole block fits right of or below this one
    frame_end = ((32'(col_base) + 32'(scale) + 32'(scale)) > 32'(cols)) &&
                ((32'(row_base) + 32'(scale) + 32'(scale)) > 32'(rows));
    acc_blk  = accept && in_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_reg <= bxavg_pkg::SCALE_REG_W'(1);
      cols_reg  <= bxavg_pkg::COLS_REG_W'(1024);
      rows_reg  <= bxavg_pkg::ROWS_REG_W'(768);
      src_col   <= '0;
      src_row   <= '0;
      blk_x     <= '0;
      blk_y     <= '0;
      col_base  <= '0;
      row_base  <= '0;
      cib       <= '0;
      rib       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bxavg_pkg::REG_SCALE: scale_reg <= cfg_data[bxavg_pkg::SCALE_REG_W-1:0];
        bxavg_pkg::REG_COLS:  cols_reg  <= cfg_data[bxavg_pkg::COLS_REG_W-1:0];
        bxavg_pkg::REG_ROWS:  rows_reg  <= cfg_data[bxavg_pkg::ROWS_REG_W-1:0];
        default: ;
      endcase
      src_col  <= '0;
      src_row  <= '0;
      blk_x    <= '0;
      blk_y    <= '0;
      col_base <= '0;
      row_base <= '0;
      cib      <= '0;
      rib      <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        src_col  <= '0;
        blk_x    <= '0;
        col_base <= '0;
        cib      <= '0;
        if (row_wrap) begin
          src_row  <= '0;
          blk_y    <= '0;
          row_base <= '0;
          rib      <= '0;
        end else begin
          src_row <= src_row + ROW_W'(1);
          if (rib_wrap) begin
            rib      <= '0;
            blk_y    <= blk_y + ROW_W'(1);
            row_base <= ROW_W'(32'(row_base) + 32'(scale));
          end else begin
            rib <= rib + CIB_W'(1);
          end
        end
      end else begin
        src_col <= src_col + COL_W'(1);
        if (cib_wrap) begin
          cib      <= '0;
          blk_x    <= blk_x + COL_W'(1);
          col_base <= COL_W'(32'(col_base) + 32'(scale));
        end else begin
          cib <= cib + CIB_W'(1);
        end
      end
    end
  end

  // column-sum memory: read at accept, write back from the read/modify stage
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= sum_mem[blk_x];
      if (a_valid) sum_mem[a_addr] <= a_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      wb_valid <= 1'b0;
    end else if (adv) begin
      a_valid  <= acc_blk;
      wb_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_first <= first;
      a_last  <= last;
      a_addr  <= blk_x;
      a_px    <= {pix.in_blue, pix.in_green, pix.in_red};
      a_tag   <= '{out_x: bxavg_pkg::OUTX_W'(blk_x),
                   out_y: bxavg_pkg::OUTY_W'(blk_y),
                   frame_last: frame_end};
      wb_addr <= a_addr;
      wb_data <= a_sum;
    end
  end

  // first pixel of a block starts the sum; else add to stored or forwarded sum
  always_comb begin
    if (a_first) a_base = '0;
    else if (wb_valid && (wb_addr == a_addr)) a_base = wb_data;
    else a_base = rd_data;
    for (int k = 0; k < 3; k++) begin
      a_sum[k] = a_base[k] + SUM_W'(a_px[k]);
    end
  end

  bxavg_divider #(
    .SUM_W  (SUM_W),
    .AREA_W (AREA_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (a_valid && a_last),
    .in_sum    (a_sum),
    .in_tag    (a_tag),
    .area      (area),
    .out_valid (div_valid),
    .out_mean  (div_mean),
    .out_tag   (div_tag)
  );

  assign res.valid      = div_valid;
  assign res.out_red    = div_mean[0];
  assign res.out_green  = div_mean[1];
  assign res.out_blue   = div_mean[2];
  assign res.out_x      = div_tag.out_x;
  assign res.out_y      = div_tag.out_y;
  assign res.frame_last = div_tag.frame_last;

endmodule

// ===== sv/bxavg_checker.sv =====
// Port-level checks of the box average downscaler, bound to its top level.
`timescale 1ns / 1ps
`include "box_average_downscale_defines.svh"

module bxavg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [9:0]  out_x,
  input logic [11:0] out_y,
  input logic        frame_last
);

  logic [46:0] out_word;

  assign out_word = {out_red, out_green, out_blue, out_x, out_y, frame_last};

  // a waiting word stays offered
  `BXAVG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // and unchanged
  `BXAVG_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_word))

  // nothing pending downstream: input side is open
  `BXAVG_ASSERT_IMP(a_in_open, !out_valid, in_ready)

  // pipeline empty after reset
  `BXAVG_ASSERT_RST(a_rst_empty, !out_valid)

  // input held off only while a word waits downstream
  `BXAVG_ASSERT_IMP(a_in_stall, in_valid && !in_ready, out_valid && !out_ready)

endmodule

bind box_average_downscale bxavg_checker u_bxavg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix.valid),
  .in_ready   (pix.ready),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .out_red    (res.out_red),
  .out_green  (res.out_green),
  .out_blue   (res.out_blue),
  .out_x      (res.out_x),
  .out_y      (res.out_y),
  .frame_last (res.frame_last)
);

// ===== bench/tb_box_average_downscale.sv =====
// Self-checking testbench for the box average downscaler.
`timescale 1ns / 1ps

module tb_box_average_downscale;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_BLOCK  = 16;
  localparam int ROW_CAP    = 4096;
  // Pipe is ten stages deep; give it room before touching the registers.
  localparam int PIPE_SLACK = 24;
  localparam int HOLD_CYCLES = 80;

  // The index after the three real registers: no register, but still restarts the frame.
  localparam logic [bxavg_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    FLOW_FREE,        // no gaps, no stalls
    FLOW_SRC_GAPS,    // sender idle 73 percent of the time
    FLOW_SINK_STALLS, // receiver stalls 73 percent of the time
    FLOW_BOTH         // both sides at 23 percent
  } flow_t;

  typedef struct packed {
    logic [bxavg_pkg::PIX_W-1:0] red;
    logic [bxavg_pkg::PIX_W-1:0] green;
    logic [bxavg_pkg::PIX_W-1:0] blue;
  } src_pixel_t;

  typedef struct packed {
    logic [bxavg_pkg::MEAN_W-1:0] red;
    logic [bxavg_pkg::MEAN_W-1:0] green;
    logic [bxavg_pkg::MEAN_W-1:0] blue;
    bxavg_pkg::bxavg_tag_t        tag;
  } avg_word_t;

  logic                              clk;
  logic                              rst;
  logic                              cfg_write;
  logic [bxavg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bxavg_pkg::CFG_DATA_W-1:0]  cfg_data;

  bxavg_pix_if pix_ch ();
  bxavg_res_if res_ch ();

  box_average_downscale DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_ch.sink),
    .res       (res_ch.source)
  );

  // Stimulus and scoreboard state.
  src_pixel_t  pix_pending[$];   // source pixels waiting for the driver
  avg_word_t   avg_expected[$];  // averaged words predicted, oldest first
  flow_t       flow = FLOW_FREE;
  logic        pix_took = 1'b0;  // pixel word was taken at the last rising edge
  logic        hold_kick = 1'b0;
  int unsigned hold_left = 0;
  int unsigned src_gap_pct;
  int unsigned sink_stall_pct;

  int unsigned mismatches = 0;
  int unsigned pixels_pushed = 0;
  int unsigned pixels_taken = 0;
  int unsigned words_seen = 0;
  int unsigned input_stalls = 0;
  int unsigned geometries = 0;

  assign src_gap_pct    = (flow == FLOW_SRC_GAPS) ? 73 : (flow == FLOW_BOTH) ? 23 : 0;
  assign sink_stall_pct = (flow == FLOW_SINK_STALLS) ? 73 : (flow == FLOW_BOTH) ? 23 : 0;

  // Predictor state: register copies, raster position and column sums.
  logic [bxavg_pkg::SCALE_REG_W-1:0] scale_q;
  logic [bxavg_pkg::COLS_REG_W-1:0]  cols_q;
  logic [bxavg_pkg::ROWS_REG_W-1:0]  rows_q;
  int unsigned col_at, row_at, col_in_blk, row_in_blk;
  int unsigned blk_sum [MAX_COLS][3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(4_000_000);
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [11:0] got,
                             input logic [11:0] want);
    if (got !== want)
      flag_mismatch($sformatf("word %0d %s: got %0d, want %0d", words_seen, what, got, want));
  endtask

  function automatic void rewind_frame();
    col_at = 0;
    row_at = 0;
    col_in_blk = 0;
    row_in_blk = 0;
  endfunction

  // Register write: any index, even the spare one, restarts the frame.
  function automatic void apply_register(input logic [bxavg_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [bxavg_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bxavg_pkg::REG_SCALE: scale_q = val[bxavg_pkg::SCALE_REG_W-1:0];
      bxavg_pkg::REG_COLS:  cols_q  = val[bxavg_pkg::COLS_REG_W-1:0];
      bxavg_pkg::REG_ROWS:  rows_q  = val[bxavg_pkg::ROWS_REG_W-1:0];
      default: ;
    endcase
    rewind_frame();
  endfunction

  // Fold one source pixel into its block; queue a word when the block closes.
  function automatic void accumulate_pixel(input src_pixel_t px);
    int unsigned s, nc, nr, ocols, orows, bx, by, area;
    int unsigned chan [3];
    avg_word_t w;
    // zero means 1; scale saturates at 16, columns at 1024, rows at 4096
    s  = (scale_q == 0) ? 1 : (scale_q > MAX_BLOCK) ? MAX_BLOCK : scale_q;
    nc = (cols_q == 0) ? 1 : (cols_q > MAX_COLS) ? MAX_COLS : cols_q;
    nr = (rows_q == 0) ? 1 : (rows_q > ROW_CAP) ? ROW_CAP : rows_q;
    ocols = nc / s;
    orows = nr / s;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    bx = col_at / s;
    by = row_at / s;
    // pixels right of or below the last whole block fall through untouched
    if (bx < ocols && by < orows) begin
      for (int k = 0; k < 3; k++) begin
        if (col_in_blk == 0 && row_in_blk == 0) blk_sum[bx][k] = chan[k];
        else blk_sum[bx][k] += chan[k];
      end
      if (col_in_blk == s - 1 && row_in_blk == s - 1) begin
        area = s * s;
        w.red            = bxavg_pkg::MEAN_W'(blk_sum[bx][0] / area);
        w.green          = bxavg_pkg::MEAN_W'(blk_sum[bx][1] / area);
        w.blue           = bxavg_pkg::MEAN_W'(blk_sum[bx][2] / area);
        w.tag.out_x      = bxavg_pkg::OUTX_W'(bx);
        w.tag.out_y      = bxavg_pkg::OUTY_W'(by);
        w.tag.frame_last = (bx == ocols - 1) && (by == orows - 1);
        avg_expected.push_back(w);
      end
    end
    // raster advance; the frame wraps after its last pixel
    if (col_at + 1 >= nc) begin
      col_at = 0;
      col_in_blk = 0;
      if (row_at + 1 >= nr) begin
        row_at = 0;
        row_in_blk = 0;
      end else begin
        row_at++;
        row_in_blk = (row_in_blk + 1 >= s) ? 0 : row_in_blk + 1;
      end
    end else begin
      col_at++;
      col_in_blk = (col_in_blk + 1 >= s) ? 0 : col_in_blk + 1;
    end
  endfunction

  // Long receiver hold-off, counted here so the sender keeps pushing into a full pipe.
  always @(posedge clk) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Pixel driver: next word goes out on the falling edge after the last one was taken.
  always @(negedge clk) begin : feed
    src_pixel_t nxt;
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_took) begin
      if (pix_pending.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        nxt = pix_pending.pop_front();
        pix_ch.valid    <= 1'b1;
        pix_ch.in_red   <= nxt.red;
        pix_ch.in_green <= nxt.green;
        pix_ch.in_blue  <= nxt.blue;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus the forced hold-off.
  always @(negedge clk) begin
    res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: register writes and pixel words feed the predictor, result words are checked.
  always @(posedge clk) begin : observe
    avg_word_t want;
    pix_took <= pix_ch.valid && pix_ch.ready;
    if (rst) begin
      scale_q = bxavg_pkg::SCALE_REG_W'(1);
      cols_q  = bxavg_pkg::COLS_REG_W'(1024);
      rows_q  = bxavg_pkg::ROWS_REG_W'(768);
      rewind_frame();
    end else begin
      if (cfg_write) apply_register(cfg_index, cfg_data);
      if (pix_ch.valid && pix_ch.ready) begin
        accumulate_pixel({pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue});
        pixels_taken++;
      end
      if (pix_ch.valid && !pix_ch.ready) input_stalls++;
      if (res_ch.valid && res_ch.ready) begin
        if (avg_expected.size() == 0) begin
          flag_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
        end else begin
          want = avg_expected.pop_front();
          check_field("red", 12'(res_ch.out_red), 12'(want.red));
          check_field("green", 12'(res_ch.out_green), 12'(want.green));
          check_field("blue", 12'(res_ch.out_blue), 12'(want.blue));
          check_field("out_x", 12'(res_ch.out_x), 12'(want.tag.out_x));
          check_field("out_y", res_ch.out_y, want.tag.out_y);
          check_field("frame_last", 12'(res_ch.frame_last), 12'(want.tag.frame_last));
        end
        words_seen++;
      end
    end
  end

  task automatic write_reg(input logic [bxavg_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bxavg_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // All three registers, then line up on a rising edge before queueing pixels.
  task automatic set_geometry(input int unsigned s, input int unsigned c, input int unsigned r);
    write_reg(bxavg_pkg::REG_SCALE, s);
    write_reg(bxavg_pkg::REG_COLS, c);
    write_reg(bxavg_pkg::REG_ROWS, r);
    geometries++;
    @(posedge clk);
  endtask

  function automatic void push_pixel(input src_pixel_t px);
    pix_pending.push_back(px);
    pixels_pushed++;
  endfunction

  // Mostly full-range values, with some pixels whose channels are each all-zero or all-one.
  function automatic src_pixel_t random_pixel();
    src_pixel_t p;
    p = 24'($urandom);
    if ($urandom_range(7) == 0) begin
      p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  task automatic feed_random(input int unsigned s, input int unsigned c, input int unsigned r,
                             input int unsigned n, input flow_t f);
    set_geometry(s, c, r);
    flow <= f;
    repeat (n) push_pixel(random_pixel());
  endtask

  // Idle: every pixel taken, every word back, then slack for blocks still in flight.
  task automatic drain();
    while (pixels_taken != pixels_pushed || avg_expected.size() != 0) @(negedge clk);
    flow <= FLOW_FREE;
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned total, phase, n, s, c, r;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = bxavg_pkg::REG_SCALE;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.in_red = '0;
    pix_ch.in_green = '0;
    pix_ch.in_blue = '0;
    res_ch.ready = 1'b0;
    @(negedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // reset geometry is scale 1 over 1024 x 768: each pixel comes back as its own word
    push_pixel({8'h00, 8'h00, 8'h00});
    push_pixel({8'hFF, 8'hFF, 8'hFF});
    push_pixel({8'h55, 8'hAA, 8'h0F});
    push_pixel({8'hF0, 8'h33, 8'hCC});
    drain();

    // zero scale, columns and rows all act as 1: every pixel closes a 1x1 frame
    set_geometry(0, 0, 0);
    push_pixel({8'h80, 8'h01, 8'hFE});
    push_pixel({8'h7F, 8'hFE, 8'h01});
    drain();

    // scale 2 on 3 x 2: column 2 is dropped; a spare-index write mid-frame restarts it
    set_geometry(2, 3, 2);
    push_pixel({8'h12, 8'h34, 8'h56});
    push_pixel({8'h9A, 8'hBC, 8'hDE});
    push_pixel({8'h11, 8'h22, 8'h33});
    drain();
    write_reg(REG_SPARE, 13'h1FFF);
    @(posedge clk);
    push_pixel({8'hFF, 8'h00, 8'h01});
    push_pixel({8'hFE, 8'h00, 8'h02});
    push_pixel({8'h09, 8'hFF, 8'hFF});   // right of the last block
    push_pixel({8'hFF, 8'h00, 8'h03});
    push_pixel({8'hFF, 8'h01, 8'hFF});   // closes the block, truncating means
    push_pixel({8'h00, 8'hFF, 8'h00});
    drain();

    // image smaller than one block: never a word, counters just wrap
    set_geometry(3, 2, 2);
    repeat (5) push_pixel(random_pixel());
    drain();

    // --- random ---
    total = 0;
    // scale 1 makes every pixel a word; hold the receiver off so the pipe backs up
    feed_random(1, 16, 4, 100, FLOW_FREE);
    @(negedge clk);
    hold_kick <= 1'b1;
    @(negedge clk);
    hold_kick <= 1'b0;
    drain();
    total += 100;

    // scale above the limit saturates to 16: one full 16 x 16 block per frame
    feed_random(31, 17, 16, 280, FLOW_SINK_STALLS);
    drain();
    total += 280;

    // columns above the limit act as 1024: run past a full row to see the wrap
    feed_random(1, 2047, 2, 1030, FLOW_SRC_GAPS);
    drain();
    total += 1030;

    // rows above the limit; out_y climbs one per pixel on a single column
    feed_random(1, 1, 8191, 60, FLOW_BOTH);
    drain();
    total += 60;

    // top legal values everywhere; the first block row never closes here
    feed_random(16, 1024, 4096, 40, FLOW_BOTH);
    drain();
    total += 40;

    // scale 17 saturates, still larger than this image
    feed_random(17, 8, 8, 20, FLOW_FREE);
    drain();
    total += 20;

    // small random geometries, cycling through the flow-control patterns
    phase = 0;
    while (total < 1650 || phase < 8) begin
      s = ($urandom_range(5) == 0) ? $urandom_range(7, MAX_BLOCK) : $urandom_range(1, 6);
      c = $urandom_range(1, 40);
      r = $urandom_range(1, 12);
      n = $urandom_range(8, 24);
      feed_random(s, c, r, n, flow_t'(phase % 4));
      drain();
      total += n;
      phase++;
    end

    $display("Streamed %0d source pixels over %0d geometries; %0d averaged words checked.",
             pixels_taken, geometries, words_seen);
    $display("Input back-pressure on %0d cycles; %0d mismatches.", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
